>>> design/pfdt_pkg.sv
package pfdt_pkg;

   localparam int SCREEN_WIDTH  = 176;
   localparam int SCREEN_HEIGHT = 264;
   localparam int STORE_BYTES   = (SCREEN_WIDTH * SCREEN_HEIGHT + 3) / 4;
   localparam int ADDR_W        = $clog2(STORE_BYTES);
   localparam int PIX_W         = ADDR_W + 2;
   localparam int COL_W         = 8;
   localparam int ROW_W         = 9;
   localparam int SPAN_W        = 16;

   typedef enum logic [2:0] {
      OP_SET   = 3'd0,
      OP_GET   = 3'd1,
      OP_CLEAR = 3'd2,
      OP_MARK  = 3'd3,
      OP_FLUSH = 3'd4,
      OP_FULL  = 3'd5
   } op_type;

   typedef enum logic {
      REG_MAX_PARTIAL = 1'b0,
      REG_ALWAYS_FULL = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [SPAN_W-1:0] pos_x;
      logic signed [SPAN_W-1:0] pos_y;
      logic signed [SPAN_W-1:0] span_w;
      logic signed [SPAN_W-1:0] span_h;
      logic [1:0]               pixel_color;
   } req_type;

   typedef struct packed {
      logic [1:0]       read_color;
      logic             refresh_valid;
      logic             full_refresh;
      logic [COL_W-1:0] region_left;
      logic [ROW_W-1:0] region_top;
      logic [COL_W-1:0] region_right;
      logic [ROW_W-1:0] region_bottom;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   typedef struct packed {
      logic             mark;
      logic             flush;
      logic             full;
      logic [COL_W-1:0] left;
      logic [ROW_W-1:0] top;
      logic [COL_W-1:0] right;
      logic [ROW_W-1:0] bottom;
   } dirty_cmd_type;

   typedef struct packed {
      logic             valid;
      logic             full;
      logic [COL_W-1:0] left;
      logic [ROW_W-1:0] top;
      logic [COL_W-1:0] right;
      logic [ROW_W-1:0] bottom;
   } refresh_type;

endpackage

>>> design/pfdt_store.sv
module pfdt_store (
   input  logic                            clock,
   input  pfdt_pkg::wr_type                wr,
   input  logic                            rd_en,
   input  logic [pfdt_pkg::ADDR_W-1:0]     rd_addr,
   output logic [7:0]                      rd_data
);

   logic [7:0] mem [pfdt_pkg::STORE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read-first: a read at the address being written returns the old byte.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/pfdt_dirty.sv
module pfdt_dirty (
   input  logic                   clock,
   input  logic                   reset,
   input  pfdt_pkg::dirty_cmd_type cmd,
   input  logic [7:0]             max_partial,
   input  logic                   always_full,
   output pfdt_pkg::refresh_type  refresh
);

   logic                       pending_ff, pending_in;
   logic [7:0]                 count_ff, count_in;
   logic [pfdt_pkg::COL_W-1:0] left_ff, left_in, right_ff, right_in;
   logic [pfdt_pkg::ROW_W-1:0] top_ff, top_in, bottom_ff, bottom_in;
   logic                       do_full;

   always_comb begin
      pending_in = pending_ff;
      count_in   = count_ff;
      left_in    = left_ff;
      top_in     = top_ff;
      right_in   = right_ff;
      bottom_in  = bottom_ff;
      refresh    = '0;
      do_full    = cmd.full ||
                   (cmd.flush && pending_ff && (always_full || count_ff >= max_partial));

      if (cmd.mark) begin
         pending_in = 1'b1;
         if (!pending_ff) begin
            left_in   = cmd.left;
            top_in    = cmd.top;
            right_in  = cmd.right;
            bottom_in = cmd.bottom;
         end else begin
            if (cmd.left < left_ff) left_in = cmd.left;
            if (cmd.top < top_ff) top_in = cmd.top;
            if (cmd.right > right_ff) right_in = cmd.right;
            if (cmd.bottom > bottom_ff) bottom_in = cmd.bottom;
         end
      end

      if (do_full) begin
         pending_in     = 1'b0;
         count_in       = '0;
         refresh.valid  = 1'b1;
         refresh.full   = 1'b1;
         refresh.right  = pfdt_pkg::COL_W'(pfdt_pkg::SCREEN_WIDTH - 1);
         refresh.bottom = pfdt_pkg::ROW_W'(pfdt_pkg::SCREEN_HEIGHT - 1);
      end else if (cmd.flush && pending_ff) begin
         pending_in     = 1'b0;
         count_in       = count_ff + 8'd1;
         refresh.valid  = 1'b1;
         refresh.left   = left_ff;
         refresh.top    = top_ff;
         refresh.right  = right_ff;
         refresh.bottom = bottom_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         count_ff   <= '0;
         left_ff    <= '0;
         top_ff     <= '0;
         right_ff   <= '0;
         bottom_ff  <= '0;
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
         left_ff    <= left_in;
         top_ff     <= top_in;
         right_ff   <= right_in;
         bottom_ff  <= bottom_in;
      end
   end

   // A pending box is always a proper rectangle on the screen.
   assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (left_ff <= right_ff && top_ff <= bottom_ff &&
                      right_ff < pfdt_pkg::COL_W'(pfdt_pkg::SCREEN_WIDTH) &&
                      bottom_ff < pfdt_pkg::ROW_W'(pfdt_pkg::SCREEN_HEIGHT)))
      else $error("pending dirty box is malformed");

endmodule

>>> design/packed_framebuffer_dirty_tracker.sv
// A 176 x 264 framebuffer at two bits per pixel, four pixels to a byte with the first
// pixel in the top bits, plus a bounding-box dirty tracker. A command is taken when
// start is high and busy is low; its single result appears on rsp_data with rsp_valid
// high for one cycle, registered through the execute stage and the result register,
// and the receiver cannot stall it. Set pixel, get pixel, mark region, flush and full
// refresh do not raise busy, so they can follow back to back: the pixel store is a
// single-port-read, single-port-write memory with a registered read, and a read that
// meets the write of the previous command is served from a forwarding register. A
// clear holds busy high while it writes the fill byte into all 11616 bytes of the
// store, one byte per cycle. The store holds no defined contents after reset until
// it has been cleared.
module packed_framebuffer_dirty_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pfdt_pkg::req_type req_data,
   output logic              rsp_valid,
   output pfdt_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int AW = pfdt_pkg::ADDR_W;
   localparam int PW = pfdt_pkg::PIX_W;
   localparam int CW = pfdt_pkg::COL_W;
   localparam int RW = pfdt_pkg::ROW_W;

   // Configuration registers.
   logic [7:0] max_partial_ff;
   logic       always_full_ff;
   logic       cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_partial_ff <= 8'd4;
         always_full_ff <= 1'b0;
      end else if (cfg_write) begin
         unique case (pfdt_pkg::reg_index_type'(paddr[2]))
            pfdt_pkg::REG_MAX_PARTIAL: max_partial_ff <= pwdata[7:0];
            pfdt_pkg::REG_ALWAYS_FULL: always_full_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (pfdt_pkg::reg_index_type'(paddr[2]))
         pfdt_pkg::REG_MAX_PARTIAL: prdata = {24'd0, max_partial_ff};
         pfdt_pkg::REG_ALWAYS_FULL: prdata = {31'd0, always_full_ff};
         default:                   prdata = '0;
      endcase
   end

   // Decode stage: address of the pixel and clipping of a marked region.
   logic                 accept;
   logic                 on_screen;
   logic [PW-1:0]        pix_index;
   logic signed [16:0]   x_end, y_end, x_end_c, y_end_c;
   logic [15:0]          x_left, y_top;
   logic                 region_ok;
   logic [CW-1:0]        clip_right;
   logic [RW-1:0]        clip_bottom;

   assign accept = start && !busy;

   always_comb begin
      on_screen = !req_data.pos_x[15] &&
                  req_data.pos_x[14:0] < 15'(pfdt_pkg::SCREEN_WIDTH) &&
                  !req_data.pos_y[15] &&
                  req_data.pos_y[14:0] < 15'(pfdt_pkg::SCREEN_HEIGHT);
      pix_index = PW'(req_data.pos_y[RW-1:0]) * PW'(pfdt_pkg::SCREEN_WIDTH) +
                  PW'(req_data.pos_x[CW-1:0]);

      x_left  = req_data.pos_x[15] ? 16'd0 : req_data.pos_x;
      y_top   = req_data.pos_y[15] ? 16'd0 : req_data.pos_y;
      x_end   = $signed({req_data.pos_x[15], req_data.pos_x}) +
                $signed({req_data.span_w[15], req_data.span_w});
      y_end   = $signed({req_data.pos_y[15], req_data.pos_y}) +
                $signed({req_data.span_h[15], req_data.span_h});
      x_end_c = (x_end > $signed(17'(pfdt_pkg::SCREEN_WIDTH))) ?
                $signed(17'(pfdt_pkg::SCREEN_WIDTH)) : x_end;
      y_end_c = (y_end > $signed(17'(pfdt_pkg::SCREEN_HEIGHT))) ?
                $signed(17'(pfdt_pkg::SCREEN_HEIGHT)) : y_end;
      region_ok   = (x_end_c > $signed({1'b0, x_left})) &&
                    (y_end_c > $signed({1'b0, y_top}));
      clip_right  = CW'(x_end_c - 17'sd1);
      clip_bottom = RW'(y_end_c - 17'sd1);
   end

   // Execute stage registers.
   logic                    s1_valid_ff;
   logic [2:0]              s1_op_ff;
   logic                    s1_on_ff;
   logic [AW-1:0]           s1_addr_ff;
   logic [1:0]              s1_slot_ff;
   logic [1:0]              s1_color_ff;
   pfdt_pkg::dirty_cmd_type s1_cmd_ff, s1_cmd_in;

   always_comb begin
      s1_cmd_in        = '0;
      s1_cmd_in.mark   = req_data.op == pfdt_pkg::OP_MARK && region_ok;
      s1_cmd_in.flush  = req_data.op == pfdt_pkg::OP_FLUSH;
      s1_cmd_in.full   = req_data.op == pfdt_pkg::OP_FULL;
      s1_cmd_in.left   = x_left[CW-1:0];
      s1_cmd_in.top    = y_top[RW-1:0];
      s1_cmd_in.right  = clip_right;
      s1_cmd_in.bottom = clip_bottom;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_data.op;
         s1_on_ff    <= on_screen;
         s1_addr_ff  <= pix_index[PW-1:2];
         s1_slot_ff  <= pix_index[1:0];
         s1_color_ff <= req_data.pixel_color;
         s1_cmd_ff   <= s1_cmd_in;
      end
   end

   // Pixel store with forwarding of the write that lands on the read edge.
   pfdt_pkg::wr_type wr;
   logic [7:0]       rd_data;
   logic             lw_valid_ff;
   logic [AW-1:0]    lw_addr_ff;
   logic [7:0]       lw_data_ff;
   logic [7:0]       cur_byte;
   logic [7:0]       set_byte;
   logic [1:0]       get_color;
   logic             s1_set, s1_get, s1_clear;

   pfdt_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (accept && on_screen),
      .rd_addr (pix_index[PW-1:2]),
      .rd_data (rd_data)
   );

   // Clear sweep.
   logic          sweep_ff, sweep_in;
   logic [AW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [7:0]    fill_ff, fill_in;

   assign s1_set   = s1_valid_ff && s1_op_ff == pfdt_pkg::OP_SET && s1_on_ff;
   assign s1_get   = s1_valid_ff && s1_op_ff == pfdt_pkg::OP_GET && s1_on_ff;
   assign s1_clear = s1_valid_ff && s1_op_ff == pfdt_pkg::OP_CLEAR;
   assign busy     = sweep_ff || s1_clear;

   always_comb begin
      cur_byte = (lw_valid_ff && lw_addr_ff == s1_addr_ff) ? lw_data_ff : rd_data;
      set_byte = cur_byte;
      case (s1_slot_ff)
         2'd0: begin
            get_color      = cur_byte[7:6];
            set_byte[7:6]  = s1_color_ff;
         end
         2'd1: begin
            get_color      = cur_byte[5:4];
            set_byte[5:4]  = s1_color_ff;
         end
         2'd2: begin
            get_color      = cur_byte[3:2];
            set_byte[3:2]  = s1_color_ff;
         end
         default: begin
            get_color      = cur_byte[1:0];
            set_byte[1:0]  = s1_color_ff;
         end
      endcase

      if (sweep_ff) begin
         wr.en   = 1'b1;
         wr.addr = sweep_cnt_ff;
         wr.data = fill_ff;
      end else begin
         wr.en   = s1_set;
         wr.addr = s1_addr_ff;
         wr.data = set_byte;
      end

      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      fill_in      = fill_ff;
      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + AW'(1);
         if (sweep_cnt_ff == AW'(pfdt_pkg::STORE_BYTES - 1)) begin
            sweep_in = 1'b0;
         end
      end else if (s1_clear) begin
         sweep_in     = 1'b1;
         sweep_cnt_in = '0;
         fill_in      = {4{s1_color_ff}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff    <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         sweep_ff    <= sweep_in;
         lw_valid_ff <= wr.en;
      end
   end

   always_ff @(posedge clock) begin
      sweep_cnt_ff <= sweep_cnt_in;
      fill_ff      <= fill_in;
      lw_addr_ff   <= wr.addr;
      lw_data_ff   <= wr.data;
   end

   // Dirty tracker acts in the execute stage, so commands see each other in order.
   pfdt_pkg::dirty_cmd_type dirty_cmd;
   pfdt_pkg::refresh_type   refresh;

   assign dirty_cmd = s1_valid_ff ? s1_cmd_ff : '0;

   pfdt_dirty u_dirty (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dirty_cmd),
      .max_partial (max_partial_ff),
      .always_full (always_full_ff),
      .refresh     (refresh)
   );

   // Result register.
   logic              rsp_valid_ff;
   pfdt_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in               = '0;
      rsp_data_in.read_color    = s1_get ? get_color : 2'd0;
      rsp_data_in.refresh_valid = refresh.valid;
      rsp_data_in.full_refresh  = refresh.full;
      rsp_data_in.region_left   = refresh.left;
      rsp_data_in.region_top    = refresh.top;
      rsp_data_in.region_right  = refresh.right;
      rsp_data_in.region_bottom = refresh.bottom;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every accepted command gives exactly one result, through the execute stage and the result register.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("accepted command produced no result");

   // A pixel write from the execute stage never competes with the clear sweep.
   assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !s1_valid_ff)
      else $error("command in execute stage during clear sweep");

   // The sweep ends only after it has written the last byte of the store.
   assert property (@(posedge clock) disable iff (reset)
      $fell(sweep_ff) |-> $past(sweep_cnt_ff) == AW'(pfdt_pkg::STORE_BYTES - 1))
      else $error("clear sweep ended early");

   // The forwarding register always describes the write of the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      wr.en |=> (lw_valid_ff && lw_addr_ff == $past(wr.addr)))
      else $error("forwarding register out of step with store writes");

endmodule

>>> tb/sv/fb_tracker_checker.sv
module fb_tracker_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  pfdt_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  pfdt_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic [31:0]       prdata,
   input  logic              pready,
   output int                mismatches,
   output int                awaited,
   output int                answers_seen
);
   import pfdt_pkg::*;

   // Shadow copy of the framebuffer and of the dirty tracker.
   logic [7:0]  pixels [STORE_BYTES];
   int          partial_done;
   logic        box_open;
   int          box_l, box_t, box_r, box_b;
   int          max_partial;
   logic        force_full;
   rsp_type     predicted_answers [$];

   function automatic string show(rsp_type a);
      return $sformatf("colour %0d valid %0b full %0b box (%0d,%0d)-(%0d,%0d)",
                       a.read_color, a.refresh_valid, a.full_refresh,
                       a.region_left, a.region_top, a.region_right, a.region_bottom);
   endfunction

   task automatic complain(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   task automatic take_full_refresh(inout rsp_type ans);
      partial_done = 0;
      box_open = 1'b0;
      ans.refresh_valid = 1'b1;
      ans.full_refresh = 1'b1;
      ans.region_right = COL_W'(SCREEN_WIDTH - 1);
      ans.region_bottom = ROW_W'(SCREEN_HEIGHT - 1);
   endtask

   task automatic predict(input req_type cmd, output rsp_type ans);
      int x, y, w, h, n, sh, l, t, xe, ye;
      ans = '0;
      x = int'(cmd.pos_x);
      y = int'(cmd.pos_y);
      w = int'(cmd.span_w);
      h = int'(cmd.span_h);
      case (op_type'(cmd.op))
         OP_SET, OP_GET: begin
            if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT) begin
               n = y * SCREEN_WIDTH + x;
               // The first pixel of a byte sits in its top two bits.
               sh = (3 - n % 4) * 2;
               if (cmd.op == OP_SET) begin
                  pixels[n / 4][sh +: 2] = cmd.pixel_color;
               end else begin
                  ans.read_color = pixels[n / 4][sh +: 2];
               end
            end
         end
         OP_CLEAR: begin
            foreach (pixels[i]) pixels[i] = {4{cmd.pixel_color}};
         end
         OP_MARK: begin
            // Edges are clipped at full precision, so huge spans never wrap.
            l = x < 0 ? 0 : x;
            t = y < 0 ? 0 : y;
            xe = x + w;
            ye = y + h;
            if (xe > SCREEN_WIDTH) xe = SCREEN_WIDTH;
            if (ye > SCREEN_HEIGHT) ye = SCREEN_HEIGHT;
            if (xe > l && ye > t) begin
               if (!box_open) begin
                  box_l = l;
                  box_t = t;
                  box_r = xe - 1;
                  box_b = ye - 1;
                  box_open = 1'b1;
               end else begin
                  if (l < box_l) box_l = l;
                  if (t < box_t) box_t = t;
                  if (xe - 1 > box_r) box_r = xe - 1;
                  if (ye - 1 > box_b) box_b = ye - 1;
               end
            end
         end
         OP_FLUSH: begin
            if (box_open) begin
               if (force_full || partial_done >= max_partial) begin
                  take_full_refresh(ans);
               end else begin
                  partial_done++;
                  box_open = 1'b0;
                  ans.refresh_valid = 1'b1;
                  ans.region_left = COL_W'(box_l);
                  ans.region_top = ROW_W'(box_t);
                  ans.region_right = COL_W'(box_r);
                  ans.region_bottom = ROW_W'(box_b);
               end
            end
         end
         OP_FULL: begin
            take_full_refresh(ans);
         end
         default: begin
         end
      endcase
   endtask

   initial begin
      mismatches = 0;
      awaited = 0;
      answers_seen = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type fresh;
      logic [31:0] reg_value;
      if (reset) begin
         partial_done = 0;
         box_open = 1'b0;
         box_l = 0;
         box_t = 0;
         box_r = 0;
         box_b = 0;
         max_partial = 4;
         force_full = 1'b0;
         predicted_answers.delete();
      end else begin
         if (rsp_valid) begin
            answers_seen++;
            if (predicted_answers.size() == 0) begin
               complain($sformatf("unexpected result: %s", show(rsp_data)));
            end else begin
               want = predicted_answers.pop_front();
               if (rsp_data.read_color !== want.read_color
                   || rsp_data.refresh_valid !== want.refresh_valid
                   || rsp_data.full_refresh !== want.full_refresh
                   || rsp_data.region_left !== want.region_left
                   || rsp_data.region_top !== want.region_top
                   || rsp_data.region_right !== want.region_right
                   || rsp_data.region_bottom !== want.region_bottom) begin
                  complain($sformatf("result %0d: expected %s, got %s",
                                     answers_seen, show(want), show(rsp_data)));
               end
            end
         end
         if (psel && penable && pready) begin
            case (reg_index_type'(paddr[2]))
               REG_MAX_PARTIAL: reg_value = 32'(max_partial);
               default:         reg_value = 32'(force_full);
            endcase
            if (pwrite) begin
               case (reg_index_type'(paddr[2]))
                  REG_MAX_PARTIAL: max_partial = int'(pwdata[7:0]);
                  default:         force_full = pwdata[0];
               endcase
            end else if (prdata !== reg_value) begin
               complain($sformatf("register read at %0d: expected %0d, got %0d",
                                  paddr, reg_value, prdata));
            end
         end
         if (start && !busy) begin
            predict(req_data, fresh);
            predicted_answers.push_back(fresh);
         end
         awaited = predicted_answers.size();
      end
   end

endmodule

>>> tb/sv/tb.sv
module tb;
   import pfdt_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int mismatches;
   int awaited;
   int answers_seen;
   int issued;
   int clears;
   int flushes;
   int settings;
   int last_x;
   int last_y;

   int   max_setting  [8] = '{0, 255, 1, 3, 2, 255, 0, 7};
   logic full_setting [8] = '{0, 0, 0, 1, 0, 1, 1, 0};

   packed_framebuffer_dirty_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   fb_tracker_checker tracker_check (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .mismatches   (mismatches),
      .awaited      (awaited),
      .answers_seen (answers_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("packed_framebuffer_dirty_tracker regression: fail");
      $finish;
   end

   function automatic req_type cmd(op_type op, int x, int y, int w, int h, logic [1:0] c);
      req_type r;
      r.op = op;
      r.pos_x = 16'(x);
      r.pos_y = 16'(y);
      r.span_w = 16'(w);
      r.span_h = 16'(h);
      r.pixel_color = c;
      return r;
   endfunction

   // Mostly on screen, some near the edges, now and then any 16-bit value.
   function automatic int pick_coord(int extent);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return int'($urandom);
      if (r < 4) return $urandom_range(0, 7) - 4 + ($urandom_range(0, 1) ? extent : 0);
      return $urandom_range(0, extent - 1);
   endfunction

   function automatic int pick_span(int extent);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return int'($urandom);
      if (r == 1) return $urandom_range(0, 8) - 8;
      return $urandom_range(1, extent / 2);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 99) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type random_cmd();
      req_type r;
      int sel;
      int x;
      int y;
      sel = $urandom_range(0, 99);
      r = cmd(OP_SET, pick_coord(SCREEN_WIDTH), pick_coord(SCREEN_HEIGHT),
              int'($urandom), int'($urandom), 2'($urandom));
      if (sel < 30) begin
         last_x = int'(r.pos_x);
         last_y = int'(r.pos_y);
      end else if (sel < 58) begin
         r.op = OP_GET;
         // Reading within the byte just written exercises the forwarding path.
         if ($urandom_range(0, 9) < 4 && last_x >= 0 && last_x < SCREEN_WIDTH
             && last_y >= 0 && last_y < SCREEN_HEIGHT) begin
            x = (last_x & ~3) | $urandom_range(0, 3);
            y = last_y;
            r.pos_x = 16'(x);
            r.pos_y = 16'(y);
         end
      end else if (sel < 78) begin
         r.op = OP_MARK;
         r.span_w = 16'(pick_span(SCREEN_WIDTH));
         r.span_h = 16'(pick_span(SCREEN_HEIGHT));
      end else if (sel < 93) begin
         r.op = OP_FLUSH;
      end else if (sel < 97) begin
         r.op = OP_FULL;
      end else begin
         r.op = OP_FULL + 3'($urandom_range(1, 2));
      end
      return r;
   endfunction

   task automatic pause(int cycles);
      logic [95:0] junk;
      repeat (cycles) begin
         @(negedge clock);
         junk = {$urandom, $urandom, $urandom};
         start <= 1'b0;
         req_data <= junk[$bits(req_type)-1:0];
      end
   endtask

   task automatic send(req_type c, int gap);
      pause(gap);
      @(negedge clock);
      start <= 1'b1;
      req_data <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      issued++;
      if (c.op == OP_CLEAR) clears++;
      if (c.op == OP_FLUSH || c.op == OP_FULL) flushes++;
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (awaited != 0 || busy) @(negedge clock);
   endtask

   task automatic csr_access(logic write, reg_index_type idx, logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      logic no_idle;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      issued = 0;
      clears = 0;
      flushes = 0;
      settings = 1;
      last_x = 0;
      last_y = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Reset values of both registers.
      csr_access(1'b0, REG_MAX_PARTIAL, '0);
      csr_access(1'b0, REG_ALWAYS_FULL, '0);

      // Directed commands; the tracker needs no clear, pixel reads do.
      send(cmd(OP_MARK, 5, 6, 3, 4, 2'd0), 0);
      send(cmd(OP_FLUSH, 0, 0, 0, 0, 2'd0), 0);
      send(cmd(OP_CLEAR, 0, 0, 0, 0, 2'd2), 0);
      send(cmd(OP_GET, 0, 0, 0, 0, 2'd0), 0);
      send(cmd(OP_SET, 0, 0, 0, 0, 2'd3), 0);
      send(cmd(OP_SET, 175, 263, 0, 0, 2'd1), 0);
      send(cmd(OP_SET, 1, 0, 0, 0, 2'd0), 0);
      send(cmd(OP_GET, 0, 0, 0, 0, 2'd0), 0);
      send(cmd(OP_GET, 1, 0, 0, 0, 2'd0), 0);
      send(cmd(OP_GET, 175, 263, 0, 0, 2'd0), 0);
      send(cmd(OP_SET, -1, 0, 0, 0, 2'd3), 0);
      send(cmd(OP_SET, 176, 0, 0, 0, 2'd3), 0);
      send(cmd(OP_GET, 0, 1, 0, 0, 2'd0), 0);
      send(cmd(OP_GET, -32768, 32767, 0, 0, 2'd0), 0);
      send(cmd(OP_GET, 32767, -32768, 0, 0, 2'd0), 0);
      send(cmd(OP_MARK, -32768, -32768, 32767, 32767, 2'd0), 0);
      send(cmd(OP_MARK, -10, -10, 32767, 32767, 2'd0), 0);
      send(cmd(OP_MARK, 3, 3, 0, 5, 2'd0), 0);
      send(cmd(OP_MARK, 3, 3, -5, 5, 2'd0), 0);
      send(cmd(OP_FLUSH, 0, 0, 0, 0, 2'd0), 0);
      send(cmd(OP_FLUSH, 0, 0, 0, 0, 2'd0), 0);
      send(cmd(OP_FULL, 0, 0, 0, 0, 2'd0), 0);
      send(cmd(op_type'(OP_FULL + 3'd1), 0, 0, 0, 0, 2'd0), 0);
      send(cmd(op_type'(OP_FULL + 3'd2), 0, 0, 0, 0, 2'd0), 0);

      // Random phases, each under its own register setting.
      max_setting[7] = $urandom_range(0, 255);
      for (int p = 0; p < 8; p++) begin
         settle();
         csr_access(1'b1, REG_MAX_PARTIAL, 32'(max_setting[p]));
         csr_access(1'b1, REG_ALWAYS_FULL, 32'(full_setting[p]));
         csr_access(1'b0, REG_MAX_PARTIAL, '0);
         csr_access(1'b0, REG_ALWAYS_FULL, '0);
         settings++;
         no_idle = (p % 3 == 2);
         send(cmd(OP_CLEAR, 0, 0, 0, 0, 2'(p)), 0);
         for (int i = 0; i < 250; i++) begin
            send(random_cmd(), no_idle ? 0 : pick_gap());
         end
      end

      settle();
      repeat (4) @(negedge clock);
      $display("%0d commands sent (%0d clears, %0d flushes or refreshes), %0d results seen",
               issued, clears, flushes, answers_seen);
      $display("across %0d register settings", settings);
      if (mismatches == 0 && awaited == 0) begin
         $display("packed_framebuffer_dirty_tracker regression: pass");
      end else begin
         $display("packed_framebuffer_dirty_tracker regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
design/pfdt_pkg.sv
design/pfdt_store.sv
design/pfdt_dirty.sv
design/packed_framebuffer_dirty_tracker.sv
tb/sv/fb_tracker_checker.sv
tb/sv/tb.sv
